@@ rtl/faim_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// faim_pkg
// shared types and constants of the frame address index map unit
// ----------------------------------------------------------------------------
package faim_pkg;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned LIMIT_W  = 7;
  localparam int unsigned FADDR_W  = 24;
  localparam int unsigned INDEX_W  = 15;
  localparam int unsigned RADDR_W  = 17;
  localparam int unsigned MAJOR_W  = 8;

  // item modes
  localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FWD  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INV  = 2'd2;

  // tag that sits above major and minor in a frame address
  localparam logic [FADDR_W-1:0] UPPER_TAG = 24'd3;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [SLOT_W-1:0]  table_slot;
    logic [LIMIT_W-1:0] limit_value;
    logic [FADDR_W-1:0] frame_address;
    logic [INDEX_W-1:0] linear_index;
  } faim_in_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index_out;
    logic [RADDR_W-1:0] address_out;
    logic [MAJOR_W-1:0] major_out;
    logic               addr_valid;
    logic               in_range;
  } faim_out_t;

  // controller to datapath
  typedef struct packed {
    logic start;   // capture item, write table on load
    logic rd;      // issue table read at walk pointer
    logic finish;  // capture result
    logic emit;    // move result to output register
  } faim_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic imm;       // item needs no table walk
    logic hit;       // walk ends on the entry in hand
    logic out_free;  // output register can take a beat
  } faim_sts_t;

endpackage

@@ rtl/faim_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// faim_ctrl
// sequencer for accept, table walk, result hold and output hand-off
// ----------------------------------------------------------------------------
module faim_ctrl import faim_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  faim_sts_t sts_i,
  output faim_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_WALK;
        end
      end
      S_WALK: begin
        cmd_o.rd = 1'b1;
        if (sts_i.imm || sts_i.hit) begin
          cmd_o.finish = 1'b1;
          state_d      = S_HOLD;
        end
      end
      S_HOLD: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/faim_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// faim_datapath
// limit table, walk pointer, running sum and remainder, result registers
// ----------------------------------------------------------------------------
module faim_datapath import faim_pkg::*; #(
  parameter int unsigned NUM_MAJORS = 256,
  parameter int unsigned MINOR_BITS = 7
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  faim_cmd_t cmd_i,
  output faim_sts_t sts_o,
  input  faim_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output faim_out_t out_data_o
);

  localparam int unsigned IdxW    = (NUM_MAJORS > 1) ? $clog2(NUM_MAJORS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_MAJORS - 1);

  // limit table
  logic [MINOR_BITS-1:0] mem [NUM_MAJORS];
  logic [NUM_MAJORS-1:0] valid_q;
  logic                  we;
  logic [IdxW-1:0]       waddr;
  logic [MINOR_BITS-1:0] rd_q;
  logic                  rv_q;

  // item and walk state
  logic [MODE_W-1:0]     mode_q;
  logic [MAJOR_W-1:0]    major_q;
  logic [MINOR_BITS-1:0] minor_q;
  logic                  upper_ok_q;
  logic [INDEX_W-1:0]    sum_q, sum_d;
  logic [INDEX_W-1:0]    rem_q, rem_d;
  logic [IdxW-1:0]       cnt_q;
  logic [IdxW-1:0]       pidx_q;
  logic                  pv_q;

  logic [MINOR_BITS-1:0] lim;
  logic [INDEX_W-1:0]    lim_inc;
  logic                  at_major;
  logic                  at_last;
  logic                  fits;
  logic                  hit;
  faim_out_t             res_d, res_q, out_q;
  logic                  out_valid_q;

  assign we    = cmd_i.start && (in_data_i.mode == MODE_LOAD) &&
                 ({1'b0, in_data_i.table_slot} < 9'(NUM_MAJORS));
  assign waddr = in_data_i.table_slot[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= in_data_i.limit_value[MINOR_BITS-1:0];
    end
    if (cmd_i.rd) begin
      rd_q <= mem[cnt_q];
      rv_q <= valid_q[cnt_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we) begin
      valid_q[waddr] <= 1'b1;
    end
  end

  // entry in hand, never-written entries read as zero
  always_comb begin
    lim      = rv_q ? rd_q : '0;
    lim_inc  = INDEX_W'(lim) + INDEX_W'(1);
    at_major = ({1'b0, major_q} == 9'(pidx_q));
    at_last  = (pidx_q == LastIdx);
    fits     = (rem_q <= INDEX_W'(lim));

    sum_d = sum_q;
    rem_d = rem_q;
    if (pv_q && !at_major) begin
      sum_d = sum_q + lim_inc;
    end
    if (pv_q && !fits) begin
      rem_d = rem_q - lim_inc;
    end

    hit   = 1'b0;
    res_d = '0;
    case (mode_q)
      MODE_FWD: begin
        hit              = pv_q && (at_major || at_last);
        res_d.index_out  = sum_d;
        res_d.major_out  = major_q;
        res_d.addr_valid = at_major && (minor_q <= lim) && upper_ok_q;
      end
      MODE_INV: begin
        hit = pv_q && (fits || at_last);
        if (fits) begin
          res_d.address_out = (RADDR_W'(3) << (MINOR_BITS + 8)) |
                              (RADDR_W'(pidx_q) << MINOR_BITS) |
                              RADDR_W'(rem_q[MINOR_BITS-1:0]);
          res_d.major_out   = MAJOR_W'(pidx_q);
          res_d.in_range    = 1'b1;
        end
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  assign sts_o.imm      = !((mode_q == MODE_FWD) || (mode_q == MODE_INV));
  assign sts_o.hit      = hit;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // item capture and walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      mode_q     <= in_data_i.mode;
      major_q    <= in_data_i.frame_address[MINOR_BITS +: MAJOR_W];
      minor_q    <= in_data_i.frame_address[MINOR_BITS-1:0];
      upper_ok_q <= ((in_data_i.frame_address >> (MINOR_BITS + 8)) == UPPER_TAG);
      sum_q      <= INDEX_W'(in_data_i.frame_address[MINOR_BITS-1:0]);
      rem_q      <= in_data_i.linear_index;
    end else begin
      sum_q <= sum_d;
      rem_q <= rem_d;
    end
    if (cmd_i.rd) begin
      pidx_q <= cnt_q;
    end
    if (cmd_i.finish) begin
      res_q <= res_d;
    end
    if (cmd_i.emit) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        cnt_q <= '0;
      end else if (cmd_i.rd && (cnt_q != LastIdx)) begin
        cnt_q <= cnt_q + IdxW'(1);
      end
      pv_q <= cmd_i.rd && !cmd_i.start;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/frame_address_index_map_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_address_index_map_unit
// maps frame addresses to dense indices and back through a table of minor
// limits per major group
// ----------------------------------------------------------------------------
// flow: load and unused mode beats finish without a table walk; forward beats
//   walk up to their major, inverse beats up to the entry holding the index
// throughput: one beat in flight; the table walk reads at most NUM_MAJORS
//   entries, one per cycle, from the single read port
// reset: asynchronous, active low; every table entry reads as zero afterwards
//   (per-entry valid bits), no clearing pass, the block takes beats at once
// ----------------------------------------------------------------------------
module frame_address_index_map_unit import faim_pkg::*; #(
  parameter int unsigned NUM_MAJORS = 256,
  parameter int unsigned MINOR_BITS = 7
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  faim_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output faim_out_t out_data_o
);

  // command and status between sequencer and datapath
  faim_cmd_t cmd;
  faim_sts_t sts;

  // sequencer: idle -> walk (one table entry per cycle) -> hold until the
  // output register is free
  faim_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // table, walk arithmetic and output register
  faim_datapath #(
    .NUM_MAJORS (NUM_MAJORS),
    .MINOR_BITS (MINOR_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
